/* sv/test_frame_checker_defines.svh */
// ----------------------------------------------------------------------------
// Test frame checker assertion macros
// Shared helpers for the concurrent checks of the frame checker.
// ----------------------------------------------------------------------------
`ifndef TEST_FRAME_CHECKER_DEFINES_SVH
`define TEST_FRAME_CHECKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tfc_pkg.sv */
// ----------------------------------------------------------------------------
// Test frame checker package
// Word types, verdict record and constants shared by the checker modules.
// ----------------------------------------------------------------------------
package tfc_pkg;

	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] END_BYTE   = 8'h03;

	// Start byte, four number bytes and end byte.
	localparam logic [16:0] FRAME_FIXED_BYTES = 17'd6;
	// Offset of the first payload byte, which is also last position minus payload length.
	localparam logic [16:0] PAYLOAD_START  = 17'd5;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LEN  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MODE = 2'd2;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_SIZE    = 3'd1,
		ERR_DELIM   = 3'd2,
		ERR_NUMBER  = 3'd3,
		ERR_PAYLOAD = 3'd4
	} err_kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       short_end;
	} in_word_t;

	typedef struct packed {
		logic        frame_ok;
		logic [2:0]  error_kind;
		logic [15:0] frame_index;
		logic [31:0] total_bytes;
		logic [15:0] good_frames;
		logic [15:0] error_frames;
		logic        run_done;
	} out_word_t;

	// Per-frame verdict handed from the classifier to the accounting stage.
	typedef struct packed {
		err_kind_t   kind;
		logic [15:0] index;
		logic        done;
		logic [16:0] frame_len;
	} verdict_t;

endpackage

/* sv/tfc_front.sv */
// ----------------------------------------------------------------------------
// Test frame checker front end
// Holds the configuration, tracks the byte position in the frame and checks
// delimiters, frame number and payload; emits one verdict per frame end.
// ----------------------------------------------------------------------------
module tfc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tfc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tfc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                accept,
	input  tfc_pkg::in_word_t                   word,
	output logic                                push,
	output tfc_pkg::verdict_t                   verdict
);

	logic [15:0] payload_len_q;
	logic [15:0] frame_count_q;
	logic        pattern_mode_q;

	logic [16:0] pos_q;
	logic [15:0] exp_q;
	logic [31:0] num_q;
	logic        delim_q;
	logic        pay_q;
	logic        fin_q;

	logic        active;
	logic [16:0] last_pos;
	logic        at_end;
	logic        end_bad;
	logic [7:0]  pay_off;
	logic [7:0]  want;
	logic [1:0]  lane;
	logic        done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_len_q  <= '0;
			frame_count_q  <= '0;
			pattern_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tfc_pkg::REG_PAYLOAD_LEN:  payload_len_q  <= cfg_data;
				tfc_pkg::REG_FRAME_COUNT:  frame_count_q  <= cfg_data;
				tfc_pkg::REG_PATTERN_MODE: pattern_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign active   = !fin_q && (exp_q < frame_count_q);
	assign last_pos = {1'b0, payload_len_q} + tfc_pkg::PAYLOAD_START;
	assign at_end   = (pos_q != '0) && (pos_q >= last_pos);
	assign end_bad  = word.data_byte != tfc_pkg::END_BYTE;
	assign pay_off  = pos_q[7:0] - tfc_pkg::PAYLOAD_START[7:0];
	assign want     = pattern_mode_q ? ~pay_off : pay_off;
	assign lane     = pos_q[1:0] - 2'd1;
	assign done     = ({1'b0, exp_q} + 17'd1) >= {1'b0, frame_count_q};

	assign push = accept && active && (word.short_end || at_end);

	always_comb begin
		verdict.index     = exp_q;
		verdict.done      = done;
		verdict.frame_len = {1'b0, payload_len_q} + tfc_pkg::FRAME_FIXED_BYTES;
		if (word.short_end) begin
			verdict.kind = tfc_pkg::ERR_SIZE;
		end else if (delim_q || end_bad) begin
			verdict.kind = tfc_pkg::ERR_DELIM;
		end else if (num_q != {16'd0, exp_q}) begin
			verdict.kind = tfc_pkg::ERR_NUMBER;
		end else if (pay_q) begin
			verdict.kind = tfc_pkg::ERR_PAYLOAD;
		end else begin
			verdict.kind = tfc_pkg::ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			exp_q   <= '0;
			num_q   <= '0;
			delim_q <= 1'b0;
			pay_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else if (push) begin
			pos_q   <= '0;
			num_q   <= '0;
			delim_q <= 1'b0;
			pay_q   <= 1'b0;
			exp_q   <= exp_q + 16'd1;
			if (done) begin
				fin_q <= 1'b1;
			end
		end else if (accept && active) begin
			pos_q <= pos_q + 17'd1;
			if (pos_q == '0) begin
				if (word.data_byte != tfc_pkg::START_BYTE) begin
					delim_q <= 1'b1;
				end
			end else if (pos_q < tfc_pkg::PAYLOAD_START) begin
				// Frame number arrives least significant byte first.
				num_q[8*lane +: 8] <= word.data_byte;
			end else if (word.data_byte != want) begin
				pay_q <= 1'b1;
			end
		end
	end

endmodule

/* sv/tfc_queue.sv */
// ----------------------------------------------------------------------------
// Test frame checker verdict queue
// Small first-in first-out buffer between the classifier and the accounting.
// ----------------------------------------------------------------------------
module tfc_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tfc_pkg::verdict_t wdata,
	input  logic              pop,
	output tfc_pkg::verdict_t rdata,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	tfc_pkg::verdict_t slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = cnt_q == FULL_CNT;
	assign empty = cnt_q == '0;
	assign rdata = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/tfc_back.sv */
// ----------------------------------------------------------------------------
// Test frame checker accounting stage
// Updates the saturating totals per verdict and holds the result register.
// ----------------------------------------------------------------------------
`include "test_frame_checker_defines.svh"

module tfc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  tfc_pkg::verdict_t  verdict,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output tfc_pkg::out_word_t result
);

	logic [15:0] good_q;
	logic [15:0] bad_q;
	logic [31:0] total_q;
	logic        out_valid_q;
	tfc_pkg::out_word_t out_q;

	logic        ok;
	logic [15:0] good_nx;
	logic [15:0] bad_nx;
	logic [32:0] total_sum;
	logic [31:0] total_nx;

	assign pop = !empty && (!out_valid_q || !result_stall);
	assign ok  = verdict.kind == tfc_pkg::ERR_NONE;

	always_comb begin
		good_nx   = good_q;
		bad_nx    = bad_q;
		total_nx  = total_q;
		total_sum = {1'b0, total_q} + {16'd0, verdict.frame_len};
		if (ok) begin
			if (good_q != 16'hFFFF) begin
				good_nx = good_q + 16'd1;
			end
			total_nx = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
		end else if (bad_q != 16'hFFFF) begin
			bad_nx = bad_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			good_q      <= '0;
			bad_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				good_q      <= good_nx;
				bad_q       <= bad_nx;
				total_q     <= total_nx;
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.frame_ok     <= ok;
			out_q.error_kind   <= verdict.kind;
			out_q.frame_index  <= verdict.index;
			out_q.total_bytes  <= total_nx;
			out_q.good_frames  <= good_nx;
			out_q.error_frames <= bad_nx;
			out_q.run_done     <= verdict.done;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`TFC_ASSERT_SAME(a_ok_kind, clk, arst_n, out_valid_q && out_q.frame_ok, out_q.error_kind == tfc_pkg::ERR_NONE, "good word carries an error kind")
	`TFC_ASSERT_NEXT(a_pop_shows, clk, arst_n, pop, out_valid_q, "popped verdict not shown in the result register")
	`TFC_ASSERT_SAME(a_bad_counted, clk, arst_n, out_valid_q && !out_q.frame_ok, out_q.error_frames != 16'd0, "bad frame reported with a zero error count")
	`TFC_ASSERT_SAME(a_good_bytes, clk, arst_n, out_valid_q && out_q.frame_ok, out_q.total_bytes != 32'd0 && out_q.good_frames != 16'd0, "good frame reported with empty totals")

endmodule

/* sv/test_frame_checker.sv */
// ----------------------------------------------------------------------------
// Test frame checker
// Checks a stream of link-test frames byte by byte and reports one result
// word per frame with the verdict and running totals.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while the verdict queue is not full,
// including frame ends. The verdict of the end byte or short-end word is
// written to the verdict queue and moved from there to the result register.
// The verdict queue of QUEUE_DEPTH entries absorbs output stalls; input stalls
// only when it is full. Reset clears all control state, the configuration
// registers and the totals; no clearing pass is needed.
module test_frame_checker #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  tfc_pkg::in_word_t               item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output tfc_pkg::out_word_t              result
);

	logic              accept;
	logic              push;
	logic              pop;
	logic              full;
	logic              empty;
	tfc_pkg::verdict_t verdict_in;
	tfc_pkg::verdict_t verdict_out;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	tfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.word      (item),
		.push      (push),
		.verdict   (verdict_in)
	);

	tfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (verdict_in),
		.pop    (pop),
		.rdata  (verdict_out),
		.full   (full),
		.empty  (empty)
	);

	tfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.verdict      (verdict_out),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* tb/sv/test_frame_checker_tb.sv */
// ----------------------------------------------------------------------------
// Test frame checker testbench
// Feeds link-test frames (good, corrupted, truncated, overlong and noise)
// through the checker under random sender gaps and receiver stalls. A local
// frame tracker predicts every verdict word, and each result is compared
// field by field in order.
// ----------------------------------------------------------------------------
module test_frame_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {
		SHAPE_GOOD,
		SHAPE_CORRUPT,
		SHAPE_NUMBER,
		SHAPE_TRUNC,
		SHAPE_EXTEND,
		SHAPE_NOISE
	} frame_shape_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tfc_pkg::CFG_INDEX_W-1:0] cfg_index = tfc_pkg::REG_PAYLOAD_LEN;
	logic [tfc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                            item_valid = 1'b0;
	logic                            item_stall;
	tfc_pkg::in_word_t               item = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	tfc_pkg::out_word_t              result;

	test_frame_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #4 clk = ~clk;

	// Words waiting to be sent; the head is the one on the bus while valid.
	tfc_pkg::in_word_t  byte_queue[$];
	tfc_pkg::out_word_t awaited_verdicts[$];
	int                 queued_words = 0;
	int                 mismatches = 0;
	logic               hold_sender = 1'b0;

	// Frame tracker state, mirrors the checker.
	logic [15:0] cfg_payload_len = '0;
	logic [15:0] cfg_frame_count = '0;
	logic        cfg_descending = 1'b0;
	logic [16:0] frame_pos = '0;
	logic [15:0] next_index = '0;
	logic [31:0] gathered_number = '0;
	logic        delim_err = 1'b0;
	logic        pattern_err = 1'b0;
	logic [15:0] good_tally = '0;
	logic [15:0] bad_tally = '0;
	logic [31:0] good_byte_total = '0;
	logic        run_over = 1'b0;

	// Generator view of the settings and of the next frame number.
	int   gen_len = 0;
	logic gen_descending = 1'b0;
	int   plan_index = 0;

	function automatic tfc_pkg::out_word_t close_frame(bit cut_short);
		tfc_pkg::out_word_t verdict;
		tfc_pkg::err_kind_t kind;
		logic [16:0]        flen;
		logic [32:0]        sum;
		logic               last_frame;
		flen = {1'b0, cfg_payload_len} + tfc_pkg::FRAME_FIXED_BYTES;
		if (cut_short)
			kind = tfc_pkg::ERR_SIZE;
		else if (delim_err)
			kind = tfc_pkg::ERR_DELIM;
		else if (gathered_number != {16'h0, next_index})
			kind = tfc_pkg::ERR_NUMBER;
		else if (pattern_err)
			kind = tfc_pkg::ERR_PAYLOAD;
		else
			kind = tfc_pkg::ERR_NONE;
		if (kind == tfc_pkg::ERR_NONE) begin
			if (good_tally != 16'hFFFF)
				good_tally++;
			sum = {1'b0, good_byte_total} + flen;
			good_byte_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end else if (bad_tally != 16'hFFFF) begin
			bad_tally++;
		end
		last_frame = ({1'b0, next_index} + 17'd1) >= {1'b0, cfg_frame_count};
		verdict.frame_ok = (kind == tfc_pkg::ERR_NONE);
		verdict.error_kind = kind;
		verdict.frame_index = next_index;
		verdict.total_bytes = good_byte_total;
		verdict.good_frames = good_tally;
		verdict.error_frames = bad_tally;
		verdict.run_done = last_frame;
		next_index++;
		if (last_frame)
			run_over = 1'b1;
		frame_pos = '0;
		gathered_number = '0;
		delim_err = 1'b0;
		pattern_err = 1'b0;
		return verdict;
	endfunction

	task automatic take_word(tfc_pkg::in_word_t w);
		logic [16:0] last_pos;
		logic [7:0]  j;
		logic [7:0]  want;
		last_pos = {1'b0, cfg_payload_len} + tfc_pkg::FRAME_FIXED_BYTES - 17'd1;
		if (run_over || next_index >= cfg_frame_count)
			return;
		if (w.short_end) begin
			awaited_verdicts.push_back(close_frame(1'b1));
			return;
		end
		if (frame_pos == 0) begin
			if (w.data_byte != tfc_pkg::START_BYTE)
				delim_err = 1'b1;
		end else if (frame_pos >= last_pos) begin
			// Also covers a frame that is already past a shortened length.
			if (w.data_byte != tfc_pkg::END_BYTE)
				delim_err = 1'b1;
			awaited_verdicts.push_back(close_frame(1'b0));
			return;
		end else if (frame_pos <= 4) begin
			gathered_number |= 32'(w.data_byte) << (8 * (frame_pos - 1));
		end else begin
			j = 8'(frame_pos - tfc_pkg::PAYLOAD_START);
			want = cfg_descending ? 8'hFF - j : j;
			if (w.data_byte != want)
				pattern_err = 1'b1;
		end
		frame_pos++;
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic check_result(tfc_pkg::out_word_t got);
		tfc_pkg::out_word_t want;
		if (awaited_verdicts.size() == 0) begin
			report_mismatch("result with none pending, frame_index", got.frame_index, 0);
			return;
		end
		want = awaited_verdicts.pop_front();
		if (got.frame_ok !== want.frame_ok)
			report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
		if (got.error_kind !== want.error_kind)
			report_mismatch("error_kind", got.error_kind, want.error_kind);
		if (got.frame_index !== want.frame_index)
			report_mismatch("frame_index", got.frame_index, want.frame_index);
		if (got.total_bytes !== want.total_bytes)
			report_mismatch("total_bytes", got.total_bytes, want.total_bytes);
		if (got.good_frames !== want.good_frames)
			report_mismatch("good_frames", got.good_frames, want.good_frames);
		if (got.error_frames !== want.error_frames)
			report_mismatch("error_frames", got.error_frames, want.error_frames);
		if (got.run_done !== want.run_done)
			report_mismatch("run_done", got.run_done, want.run_done);
	endtask

	// Driver: bursts of words with random gaps, payload held while stalled.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				void'(byte_queue.pop_front());
			if (!item_valid || !item_stall) begin
				if (hold_sender || byte_queue.size() == 0) begin
					item_valid <= 1'b0;
				end else if (gap_left > 0) begin
					item_valid <= 1'b0;
					gap_left--;
				end else begin
					item_valid <= 1'b1;
					item <= byte_queue[0];
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 7) == 0) ?
							$urandom_range(100, 400) : $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Monitor: tracks accepted words and register writes, checks results and
	// drives the receiver stall pattern.
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					tfc_pkg::REG_PAYLOAD_LEN:  cfg_payload_len = cfg_data;
					tfc_pkg::REG_FRAME_COUNT:  cfg_frame_count = cfg_data;
					tfc_pkg::REG_PATTERN_MODE: cfg_descending = cfg_data[0];
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				take_word(item);
			if (result_valid && !result_stall)
				check_result(result);
			if (stall_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(16, 160);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 7) == 0);
				STALL_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
				default:     result_stall <= ~result_stall;
			endcase
		end
	end

	task automatic queue_byte(logic [7:0] b);
		byte_queue.push_back('{data_byte: b, short_end: 1'b0});
		queued_words++;
	endtask

	task automatic queue_short();
		byte_queue.push_back('{data_byte: 8'($urandom), short_end: 1'b1});
		queued_words++;
	endtask

	function automatic logic [7:0] frame_byte(int p, int flen, logic [31:0] number);
		if (p == 0)
			return tfc_pkg::START_BYTE;
		if (p <= 4)
			return number[8 * (p - 1) +: 8];
		if (p == flen - 1)
			return tfc_pkg::END_BYTE;
		return gen_descending ? 8'(255 - (p - 5) % 256) : 8'((p - 5) % 256);
	endfunction

	// For a corrupted frame, spot is the byte to invert; for a truncated one it
	// is the number of bytes sent before the short end. Negative means random.
	task automatic queue_frame(frame_shape_t shape, int spot = -1);
		int          flen;
		int          cut;
		int          p;
		logic [31:0] number;
		logic [7:0]  b;
		flen = gen_len + 6;
		number = {16'h0, 16'(plan_index)};
		if (shape == SHAPE_NUMBER)
			number[31:16] = 16'($urandom_range(1, 16'hFFFF));
		cut = flen;
		if (shape == SHAPE_TRUNC)
			cut = (spot >= 0) ? spot : $urandom_range(0, flen - 1);
		if (shape == SHAPE_NOISE)
			cut = $urandom_range(0, flen - 1);
		if (shape == SHAPE_CORRUPT && spot < 0)
			spot = $urandom_range(0, flen - 1);
		for (p = 0; p < cut; p++) begin
			b = (shape == SHAPE_NOISE) ? 8'($urandom) : frame_byte(p, flen, number);
			if (shape == SHAPE_CORRUPT && p == spot)
				b = ~b;
			queue_byte(b);
		end
		// Extra bytes open a new frame, which the short end then closes.
		if (shape == SHAPE_EXTEND)
			repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
		if (shape == SHAPE_TRUNC || shape == SHAPE_NOISE || shape == SHAPE_EXTEND)
			queue_short();
		plan_index += (shape == SHAPE_EXTEND) ? 2 : 1;
	endtask

	task automatic write_reg(logic [tfc_pkg::CFG_INDEX_W-1:0] index,
		logic [tfc_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every word is sent and every verdict has come, then lets
	// the pipeline settle.
	task automatic drain();
		do
			@(negedge clk);
		while (byte_queue.size() != 0 || item_valid || awaited_verdicts.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		#30_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int p;
		int pick;
		int phase;
		int start_words;
		int guard;
		frame_shape_t shape;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty run: with no frames expected every word is ignored.
		write_reg(tfc_pkg::REG_PAYLOAD_LEN, 16'd0);
		write_reg(tfc_pkg::REG_FRAME_COUNT, 16'd0);
		write_reg(tfc_pkg::REG_PATTERN_MODE, 16'd0);
		queue_byte(tfc_pkg::START_BYTE);
		queue_byte(8'hFF);
		queue_short();
		drain();

		// Directed frames with no payload.
		write_reg(tfc_pkg::REG_FRAME_COUNT, 16'hFFFF);
		gen_len = 0;
		gen_descending = 1'b0;
		queue_frame(SHAPE_GOOD);
		queue_frame(SHAPE_TRUNC, 0);
		queue_frame(SHAPE_CORRUPT, 0);
		queue_frame(SHAPE_CORRUPT, 5);
		queue_frame(SHAPE_NUMBER);
		drain();

		// Length shrunk mid-frame: the next byte is taken as the end byte.
		gen_len = 10;
		gen_descending = 1'b1;
		write_reg(tfc_pkg::REG_PAYLOAD_LEN, 16'd10);
		write_reg(tfc_pkg::REG_PATTERN_MODE, 16'd1);
		for (p = 0; p < 13; p++)
			queue_byte(frame_byte(p, 16, {16'h0, 16'(plan_index)}));
		drain();
		gen_len = 2;
		write_reg(tfc_pkg::REG_PAYLOAD_LEN, 16'd2);
		queue_byte(tfc_pkg::END_BYTE);
		plan_index++;
		drain();

		// Frame count lowered to the current index: words are ignored until
		// it is raised again.
		write_reg(tfc_pkg::REG_FRAME_COUNT, 16'(plan_index));
		queue_short();
		queue_byte(tfc_pkg::START_BYTE);
		drain();
		write_reg(tfc_pkg::REG_FRAME_COUNT, 16'hFFFF);

		// Longest payload length with a frame cut short early, then a payload
		// that wraps the pattern.
		gen_len = 65535;
		gen_descending = 1'b0;
		write_reg(tfc_pkg::REG_PAYLOAD_LEN, 16'hFFFF);
		write_reg(tfc_pkg::REG_PATTERN_MODE, 16'd0);
		queue_frame(SHAPE_TRUNC, 12);
		drain();
		gen_len = 260;
		gen_descending = 1'b1;
		write_reg(tfc_pkg::REG_PAYLOAD_LEN, 16'd260);
		write_reg(tfc_pkg::REG_PATTERN_MODE, 16'd1);
		queue_frame(SHAPE_GOOD);
		drain();

		phase = 0;
		start_words = queued_words;
		while (queued_words - start_words < 100) begin
			gen_len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			gen_descending = 1'($urandom_range(0, 1));
			write_reg(tfc_pkg::REG_PAYLOAD_LEN, 16'(gen_len));
			write_reg(tfc_pkg::REG_PATTERN_MODE, 16'(gen_descending));
			repeat ($urandom_range(4, 14)) begin
				pick = $urandom_range(0, 99);
				if (pick < 58)
					shape = SHAPE_GOOD;
				else if (pick < 73)
					shape = SHAPE_CORRUPT;
				else if (pick < 78)
					shape = SHAPE_NUMBER;
				else if (pick < 88)
					shape = SHAPE_TRUNC;
				else if (pick < 94)
					shape = SHAPE_EXTEND;
				else
					shape = SHAPE_NOISE;
				queue_frame(shape);
			end
			if (phase == 0) begin
				// Stop sending midway until every pending verdict is out.
				p = byte_queue.size() / 2;
				while (byte_queue.size() > p)
					@(negedge clk);
				@(posedge clk);
				hold_sender <= 1'b1;
				do
					@(negedge clk);
				while (item_valid || awaited_verdicts.size() != 0);
				@(posedge clk);
				hold_sender <= 1'b0;
			end
			drain();
			phase++;
		end

		// Close the run two frames from now; later words are ignored even
		// after the count is raised again.
		write_reg(tfc_pkg::REG_FRAME_COUNT, 16'(plan_index + 2));
		queue_frame(SHAPE_GOOD);
		queue_frame(SHAPE_GOOD);
		queue_byte(tfc_pkg::START_BYTE);
		queue_short();
		drain();
		write_reg(tfc_pkg::REG_FRAME_COUNT, 16'hFFFF);
		queue_frame(SHAPE_GOOD);
		while (byte_queue.size() != 0 || item_valid)
			@(negedge clk);
		guard = 0;
		while (awaited_verdicts.size() != 0 && guard < 2000) begin
			@(negedge clk);
			guard++;
		end
		repeat (10) @(negedge clk);
		while (awaited_verdicts.size() != 0) begin
			report_mismatch("verdict never delivered, frame_index",
				0, awaited_verdicts[0].frame_index);
			void'(awaited_verdicts.pop_front());
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/tfc_pkg.sv
sv/tfc_front.sv
sv/tfc_queue.sv
sv/tfc_back.sv
sv/test_frame_checker.sv
tb/sv/test_frame_checker_tb.sv
